FILE: rtl/core/hsv_to_rgb_converter_unit_assert.svh
// Assertion macros for the HSV to RGB converter.
// Included by the top level; no other dependencies.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSVC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSVC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/hsvc_pkg.sv
// Shared types, constants and helpers of the HSV to RGB converter.
// No dependencies; used by every module of the block.
`default_nettype none

package hsvc_pkg;

	// Number of register stages from input word to output word.
	localparam int NUM_STAGES = 6;

	// One full turn of hue and one sextant, in 1/64 degree.
	localparam logic [14:0] HUE_FULL = 15'd23040;
	localparam logic [14:0] HUE_SEXT = 15'd3840;

	// floor(rem * 256 / 15) == (rem * FRAC_RECIP) >> 16 for rem below 3840.
	localparam logic [20:0] FRAC_RECIP = 21'd1118482;

	// 255 * 65536, the full scale of the q and t numerators.
	localparam logic [23:0] FULL_SCALE = 24'd16711680;

	// floor(y / 255) == (y * DIV255_RECIP) >> 23 for y up to 65025.
	localparam logic [15:0] DIV255_RECIP = 16'd32897;

	// Hue sextants, each 60 degrees wide.
	typedef enum logic [2:0] {
		SEXT_RED_YEL = 3'd0,
		SEXT_YEL_GRN = 3'd1,
		SEXT_GRN_CYN = 3'd2,
		SEXT_CYN_BLU = 3'd3,
		SEXT_BLU_MAG = 3'd4,
		SEXT_MAG_RED = 3'd5
	} sext_t;

	// Stage enables and stage valid bits of the pipeline, index 0 is stage 1.
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} pipe_ctrl_t;

	// Start of a sextant in 1/64 degree.
	function automatic logic [14:0] sext_base(input sext_t sext);
		logic [14:0] base;
		case (sext)
			SEXT_RED_YEL: base = 15'd0;
			SEXT_YEL_GRN: base = 15'd3840;
			SEXT_GRN_CYN: base = 15'd7680;
			SEXT_CYN_BLU: base = 15'd11520;
			SEXT_BLU_MAG: base = 15'd15360;
			SEXT_MAG_RED: base = 15'd19200;
			default:      base = 15'd0;
		endcase
		return base;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hsvc_pipe_ctrl.sv
// Valid bits and stage enables of the converter pipeline.
// Depends on hsvc_pkg.
`default_nettype none

module hsvc_pipe_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output hsvc_pkg::pipe_ctrl_t    ctrl
);

	logic [hsvc_pkg::NUM_STAGES-1:0] vld_q;
	logic [hsvc_pkg::NUM_STAGES-1:0] en;

	// A stage may load when it is empty or when its word moves on.
	always_comb begin
		en[hsvc_pkg::NUM_STAGES-1] = !vld_q[hsvc_pkg::NUM_STAGES-1] || !out_stall;
		for (int i = hsvc_pkg::NUM_STAGES - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < hsvc_pkg::NUM_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = vld_q[hsvc_pkg::NUM_STAGES-1];
	assign ctrl.en   = en;
	assign ctrl.vld  = vld_q;

endmodule

`default_nettype wire

FILE: rtl/core/hsvc_hue_split.sv
// Stages 1 and 2: hue wrap, sextant and 16-bit fraction within the sextant.
// Depends on hsvc_pkg.
`default_nettype none

module hsvc_hue_split (
	input  wire logic                 clk,
	input  wire hsvc_pkg::pipe_ctrl_t ctrl,
	input  wire logic [14:0]          hue,
	input  wire logic [7:0]           saturation,
	input  wire logic [7:0]           value,
	output hsvc_pkg::sext_t           sext_s2,
	output logic [15:0]               frac_s2,
	output logic [7:0]                sat_s2,
	output logic [7:0]                val_s2
);

	logic [14:0]     hue_w;
	logic [14:0]     rem_full;
	hsvc_pkg::sext_t sext_d;
	hsvc_pkg::sext_t sext_s1;
	logic [11:0]     rem_s1;
	logic [7:0]      sat_s1;
	logic [7:0]      val_s1;
	logic [32:0]     frac_prod;

	// Wrap a hue of a full turn or more, then find its sextant.
	always_comb begin
		hue_w = (hue >= hsvc_pkg::HUE_FULL) ? (hue - hsvc_pkg::HUE_FULL) : hue;
		if (hue_w < hsvc_pkg::HUE_SEXT) begin
			sext_d = hsvc_pkg::SEXT_RED_YEL;
		end else if (hue_w < 15'd7680) begin
			sext_d = hsvc_pkg::SEXT_YEL_GRN;
		end else if (hue_w < 15'd11520) begin
			sext_d = hsvc_pkg::SEXT_GRN_CYN;
		end else if (hue_w < 15'd15360) begin
			sext_d = hsvc_pkg::SEXT_CYN_BLU;
		end else if (hue_w < 15'd19200) begin
			sext_d = hsvc_pkg::SEXT_BLU_MAG;
		end else begin
			sext_d = hsvc_pkg::SEXT_MAG_RED;
		end
		rem_full = hue_w - hsvc_pkg::sext_base(sext_d);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			sext_s1 <= sext_d;
			rem_s1  <= rem_full[11:0];
			sat_s1  <= saturation;
			val_s1  <= value;
		end
	end

	// Fraction = floor(rem * 65536 / 3840), by reciprocal multiplication.
	assign frac_prod = {9'd0, rem_s1} * {12'd0, hsvc_pkg::FRAC_RECIP};

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			sext_s2 <= sext_s1;
			frac_s2 <= frac_prod[31:16];
			sat_s2  <= sat_s1;
			val_s2  <= val_s1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/hsvc_chan_scale.sv
// Stages 3 to 5: forms p, q and t from value, saturation and hue fraction.
// Depends on hsvc_pkg.
`default_nettype none

module hsvc_chan_scale (
	input  wire logic                 clk,
	input  wire hsvc_pkg::pipe_ctrl_t ctrl,
	input  wire hsvc_pkg::sext_t      sext_s2,
	input  wire logic [15:0]          frac_s2,
	input  wire logic [7:0]           sat_s2,
	input  wire logic [7:0]           val_s2,
	output hsvc_pkg::sext_t           sext_s5,
	output logic [7:0]                sat_s5,
	output logic [7:0]                val_s5,
	output logic [7:0]                p_s5,
	output logic [7:0]                q_s5,
	output logic [7:0]                t_s5
);

	logic [23:0]     sat_frac;
	hsvc_pkg::sext_t sext_s3;
	hsvc_pkg::sext_t sext_s4;
	logic [7:0]      sat_s3;
	logic [7:0]      sat_s4;
	logic [7:0]      val_s3;
	logic [7:0]      val_s4;
	logic [23:0]     num_q_s3;
	logic [23:0]     num_t_s3;
	logic [7:0]      num_p_s3;
	logic [31:0]     prod_q;
	logic [31:0]     prod_t;
	logic [15:0]     prod_p;
	logic [15:0]     yq_s4;
	logic [15:0]     yt_s4;
	logic [15:0]     yp_s4;
	logic [31:0]     div_q;
	logic [31:0]     div_t;
	logic [31:0]     div_p;

	// Stage 3: numerators of p, q and t. The t numerator reuses s * frac.
	assign sat_frac = {16'd0, sat_s2} * {8'd0, frac_s2};

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			sext_s3  <= sext_s2;
			sat_s3   <= sat_s2;
			val_s3   <= val_s2;
			num_q_s3 <= hsvc_pkg::FULL_SCALE - sat_frac;
			num_t_s3 <= hsvc_pkg::FULL_SCALE - {sat_s2, 16'd0} + sat_frac;
			num_p_s3 <= 8'd255 - sat_s2;
		end
	end

	// Stage 4: scale by value. Dropping 16 bits of the q and t products leaves a divide by 255.
	assign prod_q = {24'd0, val_s3} * {8'd0, num_q_s3};
	assign prod_t = {24'd0, val_s3} * {8'd0, num_t_s3};
	assign prod_p = {8'd0, val_s3} * {8'd0, num_p_s3};

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			sext_s4 <= sext_s3;
			sat_s4  <= sat_s3;
			val_s4  <= val_s3;
			yq_s4   <= prod_q[31:16];
			yt_s4   <= prod_t[31:16];
			yp_s4   <= prod_p;
		end
	end

	// Stage 5: floor divide by 255 through a reciprocal multiply.
	assign div_q = {16'd0, yq_s4} * {16'd0, hsvc_pkg::DIV255_RECIP};
	assign div_t = {16'd0, yt_s4} * {16'd0, hsvc_pkg::DIV255_RECIP};
	assign div_p = {16'd0, yp_s4} * {16'd0, hsvc_pkg::DIV255_RECIP};

	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			sext_s5 <= sext_s4;
			sat_s5  <= sat_s4;
			val_s5  <= val_s4;
			q_s5    <= div_q[30:23];
			t_s5    <= div_t[30:23];
			p_s5    <= div_p[30:23];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/hsv_to_rgb_converter_unit.sv
// Top level of the HSV to RGB converter: pipeline control, datapath and channel select.
// Depends on hsvc_pkg, hsvc_pipe_ctrl, hsvc_hue_split, hsvc_chan_scale and the assert header.
`default_nettype none

`include "hsv_to_rgb_converter_unit_assert.svh"

// Converts one HSV word (hue in 1/64 degree, saturation and value as fractions
// of 255) into an 8-bit red, green and blue word, truncated. A hue of a full turn
// or more wraps once. Zero saturation gives grey. The block is a six-stage
// pipeline that takes one word in every clock cycle while the output is not
// stalled. Each stage loads when it is empty or when the stage after it moves,
// so empty stages close up behind a stalled output and in_stall rises only once
// all six stages hold a word.
// Stages: hue wrap and sextant; hue fraction; p, q and t numerators; scaling by
// value; divide by 255; channel select into the output register.
module hsv_to_rgb_converter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [14:0] hue,
	input  wire logic [7:0]  saturation,
	input  wire logic [7:0]  value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue
);

	hsvc_pkg::pipe_ctrl_t ctrl;
	hsvc_pkg::sext_t      sext_s2;
	hsvc_pkg::sext_t      sext_s5;
	logic [15:0]          frac_s2;
	logic [7:0]           sat_s2;
	logic [7:0]           val_s2;
	logic [7:0]           sat_s5;
	logic [7:0]           val_s5;
	logic [7:0]           p_s5;
	logic [7:0]           q_s5;
	logic [7:0]           t_s5;
	logic [7:0]           red_d;
	logic [7:0]           green_d;
	logic [7:0]           blue_d;
	logic [7:0]           red_s6;
	logic [7:0]           green_s6;
	logic [7:0]           blue_s6;

	hsvc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	hsvc_hue_split u_hue (
		.clk        (clk),
		.ctrl       (ctrl),
		.hue        (hue),
		.saturation (saturation),
		.value      (value),
		.sext_s2    (sext_s2),
		.frac_s2    (frac_s2),
		.sat_s2     (sat_s2),
		.val_s2     (val_s2)
	);

	hsvc_chan_scale u_scale (
		.clk     (clk),
		.ctrl    (ctrl),
		.sext_s2 (sext_s2),
		.frac_s2 (frac_s2),
		.sat_s2  (sat_s2),
		.val_s2  (val_s2),
		.sext_s5 (sext_s5),
		.sat_s5  (sat_s5),
		.val_s5  (val_s5),
		.p_s5    (p_s5),
		.q_s5    (q_s5),
		.t_s5    (t_s5)
	);

	// Route value, p, q and t to the channels by sextant; zero saturation is grey.
	always_comb begin
		case (sext_s5)
			hsvc_pkg::SEXT_RED_YEL: begin
				red_d = val_s5; green_d = t_s5;   blue_d = p_s5;
			end
			hsvc_pkg::SEXT_YEL_GRN: begin
				red_d = q_s5;   green_d = val_s5; blue_d = p_s5;
			end
			hsvc_pkg::SEXT_GRN_CYN: begin
				red_d = p_s5;   green_d = val_s5; blue_d = t_s5;
			end
			hsvc_pkg::SEXT_CYN_BLU: begin
				red_d = p_s5;   green_d = q_s5;   blue_d = val_s5;
			end
			hsvc_pkg::SEXT_BLU_MAG: begin
				red_d = t_s5;   green_d = p_s5;   blue_d = val_s5;
			end
			hsvc_pkg::SEXT_MAG_RED: begin
				red_d = val_s5; green_d = p_s5;   blue_d = q_s5;
			end
			default: begin
				red_d = val_s5; green_d = p_s5;   blue_d = q_s5;
			end
		endcase
		if (sat_s5 == 8'd0) begin
			red_d   = val_s5;
			green_d = val_s5;
			blue_d  = val_s5;
		end
	end

	// Output register; it holds its word while the output is stalled.
	always_ff @(posedge clk) begin
		if (ctrl.en[hsvc_pkg::NUM_STAGES-1]) begin
			red_s6   <= red_d;
			green_s6 <= green_d;
			blue_s6  <= blue_d;
		end
	end

	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

	// An accepted input word occupies the first stage in the next cycle.
	`HSVC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && !in_stall, ctrl.vld[0], "accepted word lost at stage 1")

	// A word with zero saturation leaves as grey.
	`HSVC_ASSERT_NEXT(a_grey_out, clk, arst_n, ctrl.en[5] && ctrl.vld[4] && (sat_s5 == 8'd0), (red == green) && (green == blue), "zero saturation not grey")

	// One channel always carries value itself.
	`HSVC_ASSERT_NEXT(a_value_channel, clk, arst_n, ctrl.en[5] && ctrl.vld[4], (red == $past(val_s5)) || (green == $past(val_s5)) || (blue == $past(val_s5)), "no channel carries value")

endmodule

`default_nettype wire
